[src/rcmp_pkg.sv]
// Package for the raised-cosine modulation profile unit.
// Holds widths, segment codes, the sideband type and the half-versine ROM builder.
// No dependencies.
package rcmp_pkg;

  localparam int COS_TABLE_DEPTH = 1024;
  localparam int IDX_W  = $clog2(COS_TABLE_DEPTH + 1);  // lookup index / quotient bits
  localparam int TIME_W = 32;
  localparam int LEN_W  = 21;                           // ramp and hold lengths
  localparam int PER_W  = LEN_W + 2;                    // period 2r+2h
  localparam int VAL_W  = 20;                           // swing, baseline
  localparam int LVL_W  = 21;                           // saturated level
  localparam int ROM_W  = 17;                           // entries 0..65536
  localparam int NUM_W  = IDX_W + LEN_W;                // f*D + r/2

  localparam logic [2:0] CFG_WINDOW_START = 3'd0;
  localparam logic [2:0] CFG_WINDOW_STOP  = 3'd1;
  localparam logic [2:0] CFG_RAMP_LENGTH  = 3'd2;
  localparam logic [2:0] CFG_HOLD_LENGTH  = 3'd3;
  localparam logic [2:0] CFG_SWING        = 3'd4;
  localparam logic [2:0] CFG_BASELINE     = 3'd5;

  typedef enum logic [1:0] {
    SEG_RISE = 2'd0,
    SEG_PEAK = 2'd1,
    SEG_FALL = 2'd2,
    SEG_BASE = 2'd3
  } seg_e;

  // sideband that rides along each beat
  typedef struct packed {
    logic win;
    seg_e seg;
  } tag_t;

  typedef logic [ROM_W-1:0] rom_t [0:COS_TABLE_DEPTH];

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint PI_Q30  = 64'sd3373259426;

  // 65536 * 0.5*(1-cos(pi*k/D)) for 2k <= D, Q30 Taylor series, Horner form
  function automatic longint half_versine(longint k);
    longint a;
    longint x2;
    longint t;
    longint p;
    longint q;
    a  = (PI_Q30 * k + COS_TABLE_DEPTH / 2) / COS_TABLE_DEPTH;
    x2 = (a * a) >>> 30;
    t  = Q30_ONE;
    for (int n = 8; n >= 1; n--) begin
      p = (x2 * t) >>> 30;
      unique case (n)
        8: q = p / 240;
        7: q = p / 182;
        6: q = p / 132;
        5: q = p / 90;
        4: q = p / 56;
        3: q = p / 30;
        2: q = p / 12;
        default: q = p / 2;
      endcase
      t = Q30_ONE - q;
      if (t < 0) t = 0;
      if (t > Q30_ONE) t = Q30_ONE;
    end
    return (Q30_ONE - t + 16384) >>> 15;
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
      if (2 * k > COS_TABLE_DEPTH) begin
        r[k] = ROM_W'(65536 - half_versine(longint'(COS_TABLE_DEPTH - k)));
      end else begin
        r[k] = ROM_W'(half_versine(longint'(k)));
      end
    end
    return r;
  endfunction

endpackage

[src/rcmp_mod_unit.sv]
// Pipelined restoring remainder: elapsed time modulo period, one bit per stage.
// Depends on rcmp_pkg.
module rcmp_mod_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  logic                         win_i,
  input  logic [rcmp_pkg::TIME_W-1:0]  dvd_i,
  input  logic [rcmp_pkg::PER_W-1:0]   per_i,
  output logic                         vld_o,
  output logic                         win_o,
  output logic [rcmp_pkg::PER_W-1:0]   rem_o
);
  import rcmp_pkg::*;

  localparam int NS = TIME_W;

  logic [PER_W-1:0]  rem_q [NS];
  logic [TIME_W-1:0] dvd_q [NS];
  logic [NS-1:0]     vld_q;
  logic [NS-1:0]     win_q;

  for (genvar j = 0; j < NS; j++) begin : g_st
    logic [PER_W-1:0]  rem_in;
    logic [TIME_W-1:0] dvd_in;
    logic              vld_in;
    logic              win_in;
    logic [PER_W:0]    trial;
    logic [PER_W:0]    diff;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = dvd_i;
      assign vld_in = vld_i;
      assign win_in = win_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign dvd_in = dvd_q[j-1];
      assign vld_in = vld_q[j-1];
      assign win_in = win_q[j-1];
    end

    assign trial = {rem_in, dvd_in[TIME_W-1]};
    assign diff  = trial - {1'b0, per_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= (trial >= {1'b0, per_i}) ? diff[PER_W-1:0] : trial[PER_W-1:0];
        dvd_q[j] <= {dvd_in[TIME_W-2:0], 1'b0};
        win_q[j] <= win_in;
      end
    end
  end

  assign vld_o = vld_q[NS-1];
  assign win_o = win_q[NS-1];
  assign rem_o = rem_q[NS-1];

endmodule

[src/rcmp_idx_unit.sv]
// Segment decode, fold of the phase, and pipelined divide to the ROM index.
// Depends on rcmp_pkg.
module rcmp_idx_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic                        win_i,
  input  logic [rcmp_pkg::PER_W-1:0]  m_i,
  input  logic [rcmp_pkg::LEN_W-1:0]  ramp_i,
  input  logic [rcmp_pkg::LEN_W-1:0]  hold_i,
  output logic                        vld_o,
  output rcmp_pkg::tag_t              tag_o,
  output logic [rcmp_pkg::IDX_W-1:0]  idx_o
);
  import rcmp_pkg::*;

  // stage A: segment and folded time
  logic [PER_W-1:0] r_ext, rh, rrh;
  seg_e             seg_d;
  logic [LEN_W-1:0] f_d;
  logic [PER_W-1:0] fall_f;

  assign r_ext  = PER_W'(ramp_i);
  assign rh     = r_ext + PER_W'(hold_i);
  assign rrh    = rh + r_ext;
  assign fall_f = rrh - m_i;

  always_comb begin
    priority if (m_i < r_ext) begin
      seg_d = SEG_RISE;
      f_d   = m_i[LEN_W-1:0];
    end else if (m_i < rh) begin
      seg_d = SEG_PEAK;
      f_d   = ramp_i;
    end else if (m_i < rrh) begin
      seg_d = SEG_FALL;
      f_d   = fall_f[LEN_W-1:0];
    end else begin
      seg_d = SEG_BASE;
      f_d   = '0;
    end
  end

  logic             a_vld_q;
  tag_t             a_tag_q;
  logic [LEN_W-1:0] a_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_tag_q <= '{win: win_i, seg: seg_d};
      a_f_q   <= f_d;
    end
  end

  // stage B: numerator f*D + r/2
  logic             b_vld_q;
  tag_t             b_tag_q;
  logic [NUM_W-1:0] b_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_tag_q <= a_tag_q;
      b_num_q <= NUM_W'(a_f_q) * NUM_W'(COS_TABLE_DEPTH) + NUM_W'(ramp_i >> 1);
    end
  end

  // quotient < 2^IDX_W, so the top LEN_W bits start below r
  logic [LEN_W-1:0] rem_q [IDX_W];
  logic [IDX_W-1:0] low_q [IDX_W];
  logic [IDX_W-1:0] quo_q [IDX_W];
  tag_t             tag_q [IDX_W];
  logic [IDX_W-1:0] vld_q;

  for (genvar j = 0; j < IDX_W; j++) begin : g_st
    logic [LEN_W-1:0] rem_in;
    logic [IDX_W-1:0] low_in;
    logic [IDX_W-1:0] quo_in;
    tag_t             tag_in;
    logic             vld_in;
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in = b_num_q[NUM_W-1:IDX_W];
      assign low_in = b_num_q[IDX_W-1:0];
      assign quo_in = '0;
      assign tag_in = b_tag_q;
      assign vld_in = b_vld_q;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign low_in = low_q[j-1];
      assign quo_in = quo_q[j-1];
      assign tag_in = tag_q[j-1];
      assign vld_in = vld_q[j-1];
    end

    assign trial = {rem_in, low_in[IDX_W-1]};
    assign diff  = trial - {1'b0, ramp_i};
    assign ge    = (trial >= {1'b0, ramp_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
        low_q[j] <= low_in << 1;
        quo_q[j] <= {quo_in[IDX_W-2:0], ge};
        tag_q[j] <= tag_in;
      end
    end
  end

  assign vld_o = vld_q[IDX_W-1];
  assign tag_o = tag_q[IDX_W-1];
  assign idx_o = quo_q[IDX_W-1];

endmodule

[src/rcmp_level_unit.sv]
// ROM lookup, swing scaling with rounding, baseline add and saturation.
// Depends on rcmp_pkg; last stage is the output register.
module rcmp_level_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  rcmp_pkg::tag_t                    tag_i,
  input  logic [rcmp_pkg::IDX_W-1:0]        idx_i,
  input  logic signed [rcmp_pkg::VAL_W-1:0] swing_i,
  input  logic signed [rcmp_pkg::VAL_W-1:0] base_i,
  output logic                              vld_o,
  output logic signed [rcmp_pkg::LVL_W-1:0] level_o,
  output logic                              win_o,
  output logic [1:0]                        seg_o
);
  import rcmp_pkg::*;

  localparam rom_t CosRom = build_rom();
  localparam int PROD_W = VAL_W + ROM_W + 1;
  localparam int SUM_W  = LVL_W + 1;

  logic [IDX_W-1:0] idx_c;
  assign idx_c = (idx_i > IDX_W'(COS_TABLE_DEPTH)) ? IDX_W'(COS_TABLE_DEPTH) : idx_i;

  // S1: ROM read
  logic             s1_vld_q;
  tag_t             s1_tag_q;
  logic [ROM_W-1:0] s1_rom_q;

  // S2: product
  logic                     s2_vld_q;
  tag_t                     s2_tag_q;
  logic signed [PROD_W-1:0] s2_prod_q;

  // S3: output
  logic                    s3_vld_q;
  logic signed [LVL_W-1:0] s3_lvl_q;
  logic                    s3_win_q;
  logic [1:0]              s3_seg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  logic signed [PROD_W-1:0] rnd;
  logic signed [SUM_W-1:0]  sum;
  logic signed [LVL_W-1:0]  sat;

  assign rnd = (s2_prod_q + PROD_W'(32768)) >>> 16;
  assign sum = SUM_W'(rnd) + SUM_W'(base_i);

  always_comb begin
    priority if (sum > SUM_W'(signed'(22'sd1048575))) begin
      sat = {1'b0, {(LVL_W-1){1'b1}}};
    end else if (sum < SUM_W'(signed'(-22'sd1048576))) begin
      sat = {1'b1, {(LVL_W-1){1'b0}}};
    end else begin
      sat = sum[LVL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_rom_q  <= CosRom[idx_c];
      s1_tag_q  <= tag_i;
      s2_prod_q <= PROD_W'(swing_i) * signed'({1'b0, s1_rom_q});
      s2_tag_q  <= s1_tag_q;
      s3_win_q  <= s2_tag_q.win;
      if (s2_tag_q.win) begin
        s3_lvl_q <= sat;
        s3_seg_q <= s2_tag_q.seg;
      end else begin
        s3_lvl_q <= LVL_W'(base_i);
        s3_seg_q <= SEG_RISE;
      end
    end
  end

  assign vld_o   = s3_vld_q;
  assign level_o = s3_lvl_q;
  assign win_o   = s3_win_q;
  assign seg_o   = s3_seg_q;

endmodule

[src/raised_cosine_modulation_profile_unit.sv]
// Top level of the raised-cosine modulation profile unit.
// Depends on rcmp_pkg, rcmp_mod_unit, rcmp_idx_unit, rcmp_level_unit.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o, one time step (time_ms_i) per beat.
//   Output channel: out_valid_o / out_stall_i, one beat per input beat with
//   level_o (signed Q4.16, saturated), in_window_o and segment_o.
//   Config: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0 start, 1 stop, 2 ramp, 3 hold, 4 swing, 5 baseline); other indices
//   are dropped. Write only while no beats are in flight.
//   Throughput: one beat per cycle while the output is not stalled. Pipeline:
//   an entry stage, a 32-stage remainder pipe for the period, segment decode
//   and numerator, one quotient bit per stage for the ROM index, then ROM
//   read, multiply and round/saturate.
//   Stall: the whole pipe freezes while the output beat is held; in_stall_o
//   follows out_valid_o && out_stall_i, no beat is lost or repeated.
//   Reset: all valid bits clear, config returns to its reset values
//   (ramp 1, everything else 0). The cosine ROM is a constant.
module raised_cosine_modulation_profile_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rcmp_pkg::TIME_W-1:0]       time_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [rcmp_pkg::LVL_W-1:0] level_o,
  output logic                              in_window_o,
  output logic [1:0]                        segment_o,
  input  logic                              cfg_we_i,
  input  logic [2:0]                        cfg_idx_i,
  input  logic [31:0]                       cfg_data_i
);
  import rcmp_pkg::*;

  // config registers
  logic [TIME_W-1:0]       start_q, stop_q;
  logic [LEN_W-1:0]        ramp_q, hold_q;
  logic signed [VAL_W-1:0] swing_q, base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      stop_q  <= '0;
      ramp_q  <= LEN_W'(1);
      hold_q  <= '0;
      swing_q <= '0;
      base_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW_START: start_q <= cfg_data_i;
        CFG_WINDOW_STOP:  stop_q  <= cfg_data_i;
        CFG_RAMP_LENGTH:  ramp_q  <= cfg_data_i[LEN_W-1:0];
        CFG_HOLD_LENGTH:  hold_q  <= cfg_data_i[LEN_W-1:0];
        CFG_SWING:        swing_q <= cfg_data_i[VAL_W-1:0];
        CFG_BASELINE:     base_q  <= cfg_data_i[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // zero ramp acts as one; the user keeps the period static while beats are in flight (not enforced here)
  logic [LEN_W-1:0] ramp_eff;
  logic [PER_W-1:0] period;
  assign ramp_eff = (ramp_q == '0) ? LEN_W'(1) : ramp_q;
  assign period   = (PER_W'(ramp_eff) + PER_W'(hold_q)) << 1;

  // global advance: hold everything while the output beat is stalled
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // entry stage: window test and elapsed time
  logic              e_vld_q, e_win_q;
  logic [TIME_W-1:0] e_el_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en) begin
      e_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_win_q <= (time_ms_i >= start_q) && (time_ms_i <= stop_q);
      e_el_q  <= time_ms_i - start_q;
    end
  end

  logic             m_vld, m_win;
  logic [PER_W-1:0] m_rem;

  rcmp_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (e_vld_q),
    .win_i  (e_win_q),
    .dvd_i  (e_el_q),
    .per_i  (period),
    .vld_o  (m_vld),
    .win_o  (m_win),
    .rem_o  (m_rem)
  );

  logic             x_vld;
  tag_t             x_tag;
  logic [IDX_W-1:0] x_idx;

  rcmp_idx_unit u_idx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (m_vld),
    .win_i  (m_win),
    .m_i    (m_rem),
    .ramp_i (ramp_eff),
    .hold_i (hold_q),
    .vld_o  (x_vld),
    .tag_o  (x_tag),
    .idx_o  (x_idx)
  );

  rcmp_level_unit u_lvl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (x_vld),
    .tag_i   (x_tag),
    .idx_i   (x_idx),
    .swing_i (swing_q),
    .base_i  (base_q),
    .vld_o   (out_valid_o),
    .level_o (level_o),
    .win_o   (in_window_o),
    .seg_o   (segment_o)
  );

endmodule

[src/rcmp_checker.sv]
// Port-level checks for the raised-cosine modulation profile unit.
// Depends on rcmp_pkg; bound to the top level below.
module rcmp_port_props (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [rcmp_pkg::LVL_W-1:0] level_o,
  input logic                              in_window_o,
  input logic [1:0]                        segment_o
);
  import rcmp_pkg::*;

  // input backpressure comes only from a held output beat
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall not tied to output stall");

  // outside the window the segment reads as rise
  a_seg_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !in_window_o) |-> (segment_o == SEG_RISE))
    else $error("segment set outside window");

  // a stalled beat stays and holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(level_o) && $stable(segment_o) && $stable(in_window_o)))
    else $error("stalled output beat changed");

endmodule

bind raised_cosine_modulation_profile_unit rcmp_port_props u_rcmp_port_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .level_o     (level_o),
  .in_window_o (in_window_o),
  .segment_o   (segment_o)
);
